/* design/sgag_pkg.sv */
package sgag_pkg;

	localparam int MAX_DIMS    = 4;
	localparam int EXTENT_BITS = 16;
	localparam int ADDR_BITS   = 48;

	localparam int IDX_BITS    = 32;
	localparam int STRIDE_BITS = 32;
	localparam int CFG_BITS    = 64;
	localparam int REG_IDX_W   = 3;
	localparam int DCNT_W      = 3;
	localparam int EB_W        = 4;
	localparam int BYTE_W      = 3;
	localparam int MAX_EB      = 8;
	localparam int DIM_W       = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

	// divider retires RADIX_BITS quotient bits per cycle
	localparam int RADIX_BITS  = 4;
	localparam int DIV_CYCLES  = IDX_BITS / RADIX_BITS;
	localparam int DIV_CNT_W   = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

	localparam logic [REG_IDX_W-1:0] REG_DIM_COUNT     = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_ELEM_BYTES    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_ELEMENT_COUNT = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_BASE_OFFSET   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_EXTENTS       = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_STRIDES_LOW   = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_STRIDES_HIGH  = 3'd6;

	typedef struct packed {
		logic [DIM_W-1:0]    dim_top;
		logic [EB_W-1:0]     eb;
		logic [BYTE_W-1:0]   byte_last;
		logic [IDX_BITS-1:0] element_count;
		logic [IDX_BITS-1:0] base;
		logic [CFG_BITS-1:0] extents;
		logic [CFG_BITS-1:0] stride_lo;
		logic [CFG_BITS-1:0] stride_hi;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic div_start;
		logic coord_take;
		logic mul;
		logic acc;
		logic scale;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic in_range;
		logic ext_zero;
		logic div_done;
		logic last_dim;
		logic last_byte;
		logic out_free;
	} sts_t;

	// extents past the packed word read as zero
	function automatic logic [EXTENT_BITS-1:0] extent_of(input logic [CFG_BITS-1:0] ext_word,
			input logic [DIM_W-1:0] d);
		logic [CFG_BITS-1:0] sh;
		sh = '0;
		if (int'(d) * EXTENT_BITS < CFG_BITS) begin
			sh = ext_word >> (int'(d) * EXTENT_BITS);
		end
		return sh[EXTENT_BITS-1:0];
	endfunction

	function automatic logic [STRIDE_BITS-1:0] stride_of(input logic [CFG_BITS-1:0] lo,
			input logic [CFG_BITS-1:0] hi, input logic [DIM_W-1:0] d);
		logic [STRIDE_BITS-1:0] s;
		unique case (int'(d))
			0: begin
				s = lo[STRIDE_BITS-1:0];
			end
			1: begin
				s = lo[CFG_BITS-1:STRIDE_BITS];
			end
			2: begin
				s = hi[STRIDE_BITS-1:0];
			end
			3: begin
				s = hi[CFG_BITS-1:STRIDE_BITS];
			end
			default: begin
				s = '0;
			end
		endcase
		return s;
	endfunction

endpackage

/* design/sgag_cfg.sv */
module sgag_cfg (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [sgag_pkg::REG_IDX_W-1:0]        cfg_index,
	input  logic [sgag_pkg::CFG_BITS-1:0]         cfg_data,
	output sgag_pkg::cfg_t                        cfg
);

	localparam int DW = sgag_pkg::DIM_W;

	logic [sgag_pkg::DCNT_W-1:0]      dim_count_q;
	logic [sgag_pkg::EB_W-1:0]        elem_bytes_q;
	logic [sgag_pkg::IDX_BITS-1:0]    element_count_q;
	logic [sgag_pkg::IDX_BITS-1:0]    base_offset_q;
	logic [sgag_pkg::CFG_BITS-1:0]    extents_q;
	logic [sgag_pkg::CFG_BITS-1:0]    strides_low_q;
	logic [sgag_pkg::CFG_BITS-1:0]    strides_high_q;
	logic [sgag_pkg::DCNT_W-1:0]      dim_m1;
	logic [sgag_pkg::EB_W-1:0]        eb_c;
	logic [sgag_pkg::EB_W-1:0]        eb_m1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_count_q     <= 3'd1;
			elem_bytes_q    <= 4'd1;
			element_count_q <= '0;
			base_offset_q   <= '0;
			extents_q       <= '0;
			strides_low_q   <= '0;
			strides_high_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				sgag_pkg::REG_DIM_COUNT: begin
					dim_count_q <= cfg_data[sgag_pkg::DCNT_W-1:0];
				end
				sgag_pkg::REG_ELEM_BYTES: begin
					elem_bytes_q <= cfg_data[sgag_pkg::EB_W-1:0];
				end
				sgag_pkg::REG_ELEMENT_COUNT: begin
					element_count_q <= cfg_data[sgag_pkg::IDX_BITS-1:0];
				end
				sgag_pkg::REG_BASE_OFFSET: begin
					base_offset_q <= cfg_data[sgag_pkg::IDX_BITS-1:0];
				end
				sgag_pkg::REG_EXTENTS: begin
					extents_q <= cfg_data;
				end
				sgag_pkg::REG_STRIDES_LOW: begin
					strides_low_q <= cfg_data;
				end
				sgag_pkg::REG_STRIDES_HIGH: begin
					strides_high_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// clamp dimension count to 1..MAX_DIMS and element size to 1..8
	assign dim_m1 = dim_count_q - 3'd1;
	assign eb_c   = (elem_bytes_q == '0) ? 4'd1 :
			(int'(elem_bytes_q) > sgag_pkg::MAX_EB) ? 4'd8 : elem_bytes_q;
	assign eb_m1  = eb_c - 4'd1;

	always_comb begin
		cfg = '0;
		if (dim_count_q == '0) begin
			cfg.dim_top = '0;
		end else if (int'(dim_count_q) > sgag_pkg::MAX_DIMS) begin
			cfg.dim_top = DW'(sgag_pkg::MAX_DIMS - 1);
		end else begin
			cfg.dim_top = dim_m1[DW-1:0];
		end
		cfg.eb            = eb_c;
		cfg.byte_last     = eb_m1[sgag_pkg::BYTE_W-1:0];
		cfg.element_count = element_count_q;
		cfg.base          = base_offset_q;
		cfg.extents       = extents_q;
		cfg.stride_lo     = strides_low_q;
		cfg.stride_hi     = strides_high_q;
	end

endmodule

/* design/sgag_div.sv */
module sgag_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [sgag_pkg::IDX_BITS-1:0]       dividend,
	input  logic [sgag_pkg::EXTENT_BITS-1:0]    divisor,
	output logic                                done,
	output logic [sgag_pkg::IDX_BITS-1:0]       quotient,
	output logic [sgag_pkg::EXTENT_BITS-1:0]    remainder
);

	localparam int XW = sgag_pkg::EXTENT_BITS;
	localparam int QW = sgag_pkg::IDX_BITS;
	localparam int CW = sgag_pkg::DIV_CNT_W;

	logic            busy_q;
	logic            done_q;
	logic [CW-1:0]   cnt_q;
	logic [QW-1:0]   q_q;
	logic [XW:0]     p_q;
	logic [XW-1:0]   dvsr_q;
	logic [QW-1:0]   q_nx;
	logic [XW:0]     p_nx;

	// restoring division, several quotient bits per cycle
	always_comb begin
		p_nx = p_q;
		q_nx = q_q;
		for (int i = 0; i < sgag_pkg::RADIX_BITS; i++) begin
			p_nx = {p_nx[XW-1:0], q_nx[QW-1]};
			q_nx = {q_nx[QW-2:0], 1'b0};
			if (p_nx >= {1'b0, dvsr_q}) begin
				p_nx    = p_nx - {1'b0, dvsr_q};
				q_nx[0] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(sgag_pkg::DIV_CYCLES - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q    <= dividend;
			p_q    <= '0;
			dvsr_q <= divisor;
		end else if (busy_q) begin
			q_q <= q_nx;
			p_q <= p_nx;
		end
	end

	assign done      = done_q;
	assign quotient  = q_q;
	assign remainder = p_q[XW-1:0];

endmodule

/* design/sgag_dp.sv */
module sgag_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sgag_pkg::cmd_t                      cmd,
	output sgag_pkg::sts_t                      sts,
	input  sgag_pkg::cfg_t                      cfg,
	input  logic [sgag_pkg::IDX_BITS-1:0]       linear_index,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic [sgag_pkg::ADDR_BITS-1:0]      src_byte_addr,
	output logic [sgag_pkg::ADDR_BITS-1:0]      dst_byte_addr,
	output logic                                last_byte
);

	localparam int AW = sgag_pkg::ADDR_BITS;
	localparam int IW = sgag_pkg::IDX_BITS;
	localparam int XW = sgag_pkg::EXTENT_BITS;
	localparam int EW = sgag_pkg::EB_W;

	logic [IW-1:0]                      idx_q;
	logic [IW-1:0]                      rem_q;
	logic [IW-1:0]                      coord_q;
	logic [AW-1:0]                      prod_q;
	logic [AW-1:0]                      off_q;
	logic [AW-1:0]                      src_q;
	logic [AW-1:0]                      dst_q;
	logic [sgag_pkg::DIM_W-1:0]         dim_q;
	logic [sgag_pkg::BYTE_W-1:0]        byte_q;
	logic                               out_valid_q;
	logic [AW-1:0]                      out_src_q;
	logic [AW-1:0]                      out_dst_q;
	logic                               out_last_q;

	logic [XW-1:0]                      ext;
	logic [sgag_pkg::STRIDE_BITS-1:0]   stride;
	logic [IW+sgag_pkg::STRIDE_BITS-1:0] prod_w;
	logic [AW+EW-1:0]                   src_w;
	logic [IW+EW-1:0]                   dst_w;
	logic                               div_done;
	logic [IW-1:0]                      div_quot;
	logic [XW-1:0]                      div_rem;

	assign ext    = sgag_pkg::extent_of(cfg.extents, dim_q);
	assign stride = sgag_pkg::stride_of(cfg.stride_lo, cfg.stride_hi, dim_q);
	assign prod_w = coord_q * stride;
	assign src_w  = off_q * cfg.eb;
	assign dst_w  = idx_q * cfg.eb;

	sgag_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (rem_q),
		.divisor   (ext),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q  <= '0;
			byte_q <= '0;
		end else begin
			if (cmd.load) begin
				dim_q <= cfg.dim_top;
			end else if (cmd.acc && dim_q != '0) begin
				dim_q <= dim_q - 1'b1;
			end
			if (cmd.scale) begin
				byte_q <= '0;
			end else if (cmd.emit) begin
				byte_q <= byte_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			idx_q <= linear_index;
			rem_q <= linear_index;
			off_q <= AW'(cfg.base);
		end
		if (cmd.coord_take) begin
			// a zero extent swallows the whole remaining index
			if (ext == '0) begin
				coord_q <= rem_q;
				rem_q   <= '0;
			end else begin
				coord_q <= IW'(div_rem);
				rem_q   <= div_quot;
			end
		end
		if (cmd.mul) begin
			prod_q <= AW'(prod_w);
		end
		if (cmd.acc) begin
			off_q <= off_q + prod_q;
		end
		if (cmd.scale) begin
			src_q <= AW'(src_w);
			dst_q <= AW'(dst_w);
		end else if (cmd.emit) begin
			src_q <= src_q + 1'b1;
			dst_q <= dst_q + 1'b1;
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_src_q  <= src_q;
			out_dst_q  <= dst_q;
			out_last_q <= sts.last_byte;
		end
	end

	always_comb begin
		sts           = '0;
		sts.in_range  = linear_index < cfg.element_count;
		sts.ext_zero  = ext == '0;
		sts.div_done  = div_done;
		sts.last_dim  = dim_q == '0;
		sts.last_byte = byte_q == cfg.byte_last;
		sts.out_free  = !out_valid_q || out_ready;
	end

	assign out_valid     = out_valid_q;
	assign src_byte_addr = out_src_q;
	assign dst_byte_addr = out_dst_q;
	assign last_byte     = out_last_q;

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> ext != '0)
		else $error("divider started with a zero extent");

	a_div_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> !div_done)
		else $error("divider done flag survived a start");

	a_last_word: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && sts.last_byte |=> out_valid_q && out_last_q)
		else $error("final byte word not marked last");

endmodule

/* design/sgag_ctrl.sv */
module sgag_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  sgag_pkg::sts_t   sts,
	output sgag_pkg::cmd_t   cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DIV   = 3'd1;
	localparam logic [2:0] S_WAIT  = 3'd2;
	localparam logic [2:0] S_MUL   = 3'd3;
	localparam logic [2:0] S_ACC   = 3'd4;
	localparam logic [2:0] S_SCALE = 3'd5;
	localparam logic [2:0] S_EMIT  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				// out-of-range index is taken and dropped
				if (in_valid && sts.in_range) begin
					cmd.load = 1'b1;
					state_nx = S_DIV;
				end
			end
			S_DIV: begin
				if (sts.ext_zero) begin
					cmd.coord_take = 1'b1;
					state_nx       = S_MUL;
				end else begin
					cmd.div_start = 1'b1;
					state_nx      = S_WAIT;
				end
			end
			S_WAIT: begin
				if (sts.div_done) begin
					cmd.coord_take = 1'b1;
					state_nx       = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul  = 1'b1;
				state_nx = S_ACC;
			end
			S_ACC: begin
				cmd.acc  = 1'b1;
				state_nx = sts.last_dim ? S_SCALE : S_DIV;
			end
			S_SCALE: begin
				cmd.scale = 1'b1;
				state_nx  = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.last_byte) begin
						state_nx = S_IDLE;
					end
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("word emitted over a pending word");

	a_take_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.coord_take && !sts.ext_zero |-> sts.div_done)
		else $error("coordinate taken before division finished");

endmodule

/* design/strided_gather_address_gen.sv */
// Steps: after the index is taken, each dimension passes S_DIV, S_WAIT until the
// 4-bit-per-cycle divider is done (skipped when its extent is zero), S_MUL and S_ACC;
// then S_SCALE and S_EMIT, one byte word per cycle while the output is free. A new
// index is taken only in S_IDLE; an out-of-range index is taken and dropped there.
// Reset: arst_n clears the control state and loads the register reset values;
// no clearing pass, the block takes words right after reset.
module strided_gather_address_gen (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [sgag_pkg::IDX_BITS-1:0]       linear_index,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [sgag_pkg::ADDR_BITS-1:0]      src_byte_addr,
	output logic [sgag_pkg::ADDR_BITS-1:0]      dst_byte_addr,
	output logic                                last_byte,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [sgag_pkg::REG_IDX_W-1:0]      cfg_index,
	input  logic [sgag_pkg::CFG_BITS-1:0]       cfg_data
);

	sgag_pkg::cfg_t cfg;
	sgag_pkg::cmd_t cmd;
	sgag_pkg::sts_t sts;

	sgag_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sgag_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sgag_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg           (cfg),
		.linear_index  (linear_index),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.src_byte_addr (src_byte_addr),
		.dst_byte_addr (dst_byte_addr),
		.last_byte     (last_byte)
	);

endmodule
